@@ src/lpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lattice path counter package
// Shared constants, sequencer states and control struct.
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_MAX_COLS    = 64;
	localparam int DEF_COUNT_WIDTH = 31;

	// fixed field widths of the stream beats
	localparam int SIZE_W     = 7;
	localparam int PATH_W     = 31;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROWS,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// per-cycle commands from the sequencer to the row update datapath
	typedef struct packed {
		logic clear;      // new request: drop overflow
		logic init_wr;    // write a one at addr
		logic rd_en;      // read addr for a row update
		logic row_start;  // first updated entry of a row
	} lpc_ctl_t;

endpackage

@@ src/lpc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/lpc_seq.sv @@
// ----------------------------------------------------------------------------
// Lattice path counter sequencer
// Clamps the grid size and walks the init pass and the row updates.
// ----------------------------------------------------------------------------
module lpc_seq
	import lpc_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SIZE_W-1:0] rows_in,
	input  logic [SIZE_W-1:0] cols_in,
	input  logic              out_free,
	output logic              idle,
	output logic              busy,
	output logic              load,
	output lpc_ctl_t          ctl,
	output logic [AW-1:0]     addr
);

	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int RCMPW = (RW > SIZE_W) ? RW : SIZE_W;
	localparam int CCMPW = (CW > SIZE_W) ? CW : SIZE_W;

	state_t        st_q, st_d;
	logic [RW-1:0] rows_q, rows_d;
	logic [CW-1:0] cols_q, cols_d;
	logic [RW-1:0] row_q, row_d;
	logic [AW-1:0] col_q, col_d;

	logic [RCMPW-1:0] rows_ext;
	logic [CCMPW-1:0] cols_ext;
	logic [RW-1:0]    rows_clamp;
	logic [CW-1:0]    cols_clamp;
	logic             last_col;
	logic             last_row;

	// zero counts as one, oversize saturates
	always_comb begin
		rows_ext = RCMPW'(rows_in);
		cols_ext = CCMPW'(cols_in);
		if (rows_ext == '0) begin
			rows_clamp = RW'(1);
		end else if (rows_ext > RCMPW'(MAX_ROWS)) begin
			rows_clamp = RW'(MAX_ROWS);
		end else begin
			rows_clamp = rows_ext[RW-1:0];
		end
		if (cols_ext == '0) begin
			cols_clamp = CW'(1);
		end else if (cols_ext > CCMPW'(MAX_COLS)) begin
			cols_clamp = CW'(MAX_COLS);
		end else begin
			cols_clamp = cols_ext[CW-1:0];
		end
	end

	assign last_col = (CW'(col_q) == cols_q - CW'(1));
	assign last_row = (row_q == rows_q - RW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		rows_q <= rows_d;
		cols_q <= cols_d;
		row_q  <= row_d;
		col_q  <= col_d;
	end

	always_comb begin
		st_d   = st_q;
		rows_d = rows_q;
		cols_d = cols_q;
		row_d  = row_q;
		col_d  = col_q;
		idle   = 1'b0;
		load   = 1'b0;
		ctl    = '0;
		addr   = col_q;
		case (st_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					ctl.clear = 1'b1;
					rows_d    = rows_clamp;
					cols_d    = cols_clamp;
					col_d     = '0;
					st_d      = ST_INIT;
				end
			end
			ST_INIT: begin
				ctl.init_wr = 1'b1;
				if (last_col) begin
					if (rows_q == RW'(1) || cols_q == CW'(1)) begin
						st_d = ST_DRAIN;
					end else begin
						row_d = RW'(1);
						col_d = AW'(1);
						st_d  = ST_ROWS;
					end
				end else begin
					col_d = col_q + AW'(1);
				end
			end
			ST_ROWS: begin
				ctl.rd_en     = 1'b1;
				ctl.row_start = (col_q == AW'(1));
				if (last_col) begin
					col_d = AW'(1);
					row_d = row_q + RW'(1);
					if (last_row) begin
						st_d = ST_DRAIN;
					end
				end else begin
					col_d = col_q + AW'(1);
				end
			end
			ST_DRAIN: begin
				// let the final write-back land
				st_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					load = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign busy = !idle;

endmodule

@@ src/lpc_update.sv @@
// ----------------------------------------------------------------------------
// Lattice path counter row update
// Read-modify-write of the row store with a saturating add and forwarding.
// ----------------------------------------------------------------------------
module lpc_update
	import lpc_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int AW          = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lpc_ctl_t               ctl,
	input  logic [AW-1:0]          addr,
	input  logic [COUNT_WIDTH-1:0] rdata,
	output logic                   ram_we,
	output logic [AW-1:0]          ram_waddr,
	output logic [COUNT_WIDTH-1:0] ram_wdata,
	output logic                   ram_re,
	output logic [AW-1:0]          ram_raddr,
	output logic [COUNT_WIDTH-1:0] count,
	output logic                   ovf
);

	localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

	logic                   valid_s1;
	logic [AW-1:0]          addr_s1;
	logic                   row_start_s1;
	logic                   fwd_s1;
	logic [COUNT_WIDTH-1:0] fwd_data_s1;
	logic [COUNT_WIDTH-1:0] left_q;
	logic [COUNT_WIDTH-1:0] last_q;
	logic                   ovf_q;

	logic [COUNT_WIDTH-1:0] old_val;
	logic [COUNT_WIDTH-1:0] left_val;
	logic [COUNT_WIDTH:0]   sum_wide;
	logic                   carry;
	logic [COUNT_WIDTH-1:0] sum;

	assign old_val  = fwd_s1 ? fwd_data_s1 : rdata;
	// entry zero of every row stays one
	assign left_val = row_start_s1 ? ONE : left_q;
	assign sum_wide = {1'b0, old_val} + {1'b0, left_val};
	assign carry    = sum_wide[COUNT_WIDTH];
	assign sum      = carry ? '1 : sum_wide[COUNT_WIDTH-1:0];

	assign ram_re    = ctl.rd_en;
	assign ram_raddr = addr;
	assign ram_we    = valid_s1 || ctl.init_wr;
	assign ram_waddr = valid_s1 ? addr_s1 : addr;
	assign ram_wdata = valid_s1 ? sum : ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			valid_s1 <= ctl.rd_en;
			// bypass the RAM when reading the entry being written back
			fwd_s1   <= ctl.rd_en && valid_s1 && (addr_s1 == addr);
			if (ctl.clear) begin
				ovf_q <= 1'b0;
			end else if (valid_s1 && carry) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1      <= addr;
		row_start_s1 <= ctl.row_start;
		fwd_data_s1  <= sum;
		if (valid_s1) begin
			left_q <= sum;
		end
		if (ram_we) begin
			last_q <= ram_wdata;
		end
	end

	assign count = last_q;
	assign ovf   = ovf_q;

endmodule

@@ src/lattice_path_count_dp.sv @@
// ----------------------------------------------------------------------------
// Lattice path counter
// Counts monotone right/down paths across a rows x cols grid.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request beat: the grid size. m_* returns one result beat
//   per request: the path count, saturated at the count maximum, and a flag
//   that is set when any partial sum saturated.
//   Sizes of zero count as one; sizes above MAX_ROWS / MAX_COLS saturate.
// Timing:
//   The row store sits in one RAM. An init pass writes cols ones, one entry
//   a cycle, then each later row reads, adds the left neighbor and writes
//   back one entry a cycle, the single RAM read and write port being the
//   limit. One request is worked at a time; s_tready is high while the
//   sequencer is idle.
// Reset and stall:
//   arst_n clears the sequencer and the output valid flag; the RAM needs no
//   clearing since every entry is written before it is read. A new request
//   may be taken while a result still waits in the output register; its
//   own result then holds until m_tready drains that register.
// ----------------------------------------------------------------------------
module lattice_path_count_dp
	import lpc_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // rows[6:0], cols[13:7], zero pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // path_count[30:0], overflow[31]
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic                   start;
	logic                   idle;
	logic                   busy;
	logic                   load;
	logic                   out_free;
	lpc_ctl_t               ctl;
	logic [AW-1:0]          addr;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic [COUNT_WIDTH-1:0] count;
	logic                   ovf;

	logic                   m_tvalid_q;
	logic [PATH_W-1:0]      path_q;
	logic                   ovf_out_q;

	assign s_tready = idle;
	assign start    = s_tvalid && idle;
	assign out_free = !m_tvalid_q || m_tready;

	lpc_seq #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.rows_in (s_tdata[SIZE_W-1:0]),
		.cols_in (s_tdata[2*SIZE_W-1:SIZE_W]),
		.out_free(out_free),
		.idle    (idle),
		.busy    (busy),
		.load    (load),
		.ctl     (ctl),
		.addr    (addr)
	);

	lpc_update #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.AW         (AW)
	) u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.addr     (addr),
		.rdata    (ram_rdata),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.count    (count),
		.ovf      (ovf)
	);

	lpc_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(MAX_COLS)
	) u_row_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			path_q    <= PATH_W'(count);
			ovf_out_q <= ovf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {ovf_out_q, path_q};

`ifndef SYNTHESIS
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> busy)
		else $error("row store written while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> busy)
		else $error("accepted request did not start");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a pending beat");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("loaded result not presented");
`endif

endmodule
